/* rtl/ouart_pkg.sv */
// Package: shared types and constants for the oversampled UART receiver.
`timescale 1ns / 1ps
package ouart_pkg;

  localparam int DataBits   = 8;
  localparam int SpbWidth   = 5;
  localparam int StartWidth = 4;
  localparam int CountWidth = 8;
  localparam int StepWidth  = $clog2(CountWidth);

  localparam logic [SpbWidth-1:0]   SpbReset   = SpbWidth'(4);
  localparam logic [StartWidth-1:0] StartReset = StartWidth'(2);

  // register indexes on the config channel
  localparam logic CfgSpb   = 1'b0;
  localparam logic CfgStart = 1'b1;

  // request kinds (s_tuser)
  localparam logic OpTick = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DATA = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  typedef struct packed {
    logic                  start;
    logic [CountWidth-1:0] dividend;
    logic [SpbWidth-1:0]   divisor;
  } mod_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SpbWidth-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic                receiving;
    logic                byte_available;
    logic [DataBits-1:0] received_byte;
  } result_t;

endpackage

/* rtl/oversampled_uart_receiver.sv */
// Top level: oversampled 8N1 UART receiver driven by a stream of sample and read requests.
`timescale 1ns / 1ps
// Usage
//   Slave stream s_*: one request per beat. s_tuser selects the kind: a sample
//   tick (s_tdata[0] is the sampled rx level, 1 = idle high) or a read, which
//   clears the new-data flag. Every request gives exactly one result.
//   Master stream m_*: result per request: held byte, new-data flag after the
//   request, and a receiving bit (data or stop phase).
//   Config channel cfg_*: index 0 = samples per bit (5 bits), index 1 =
//   consecutive low samples for a start bit (4 bits). Zero acts as one.
//   Write only while no request is in flight.
// Timing
//   Each result is registered on m_* once its request is taken; one request
//   per cycle while s_tready is high. The sample counter's remainder modulo
//   samples per bit is kept in a register; a write to samples per bit
//   rebuilds it in the bit-serial remainder unit, with s_tready low until done.
// Reset / stall
//   rst (synchronous) returns to waiting for a start bit with counter, shift
//   register, held byte and flag cleared, and both config registers at their
//   defaults (4 samples per bit, start count 2). When m_tready is low an
//   output register plus one skid stage hold results; s_tready drops only
//   once both are full (it is also low while the remainder is rebuilt).
module oversampled_uart_receiver
  import ouart_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] rx_line, [7:1] zero
  input  logic        s_tuser,   // [0] operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] received_byte, [8] byte_available,
                                 // [9] receiving, [15:10] zero
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  // config
  logic [SpbWidth-1:0]   spb_reg;
  logic [StartWidth-1:0] start_reg;
  logic [SpbWidth-1:0]   spb;
  logic [StartWidth-1:0] start_cnt;
  logic                  cfg_write;
  logic                  spb_write;

  // receiver state
  phase_t                phase, phase_next;
  logic [CountWidth-1:0] tick_count, tick_count_next;
  logic [SpbWidth-1:0]   rem, rem_next;
  logic [DataBits-1:0]   shift_byte, shift_byte_next;
  logic [DataBits-1:0]   held_byte, held_byte_next;
  logic                  new_flag, new_flag_next;

  // tick arithmetic
  logic [CountWidth-1:0] tc_inc;
  logic [SpbWidth:0]     rem_inc;
  logic [SpbWidth-1:0]   rem_tick;
  logic [CountWidth-1:0] tc_wait;

  // handshakes
  logic    accept;
  logic    pop;
  logic    out_valid, skid_valid;
  result_t out_data, skid_data, result;

  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign spb_write = cfg_write && (cfg_index == CfgSpb);

  always_ff @(posedge clk) begin
    if (rst) begin
      spb_reg   <= SpbReset;
      start_reg <= StartReset;
    end else if (cfg_write) begin
      case (cfg_index)
        CfgSpb:   spb_reg   <= cfg_data[SpbWidth-1:0];
        CfgStart: start_reg <= cfg_data[StartWidth-1:0];
        default:  ;
      endcase
    end
  end

  assign spb       = (spb_reg == '0) ? SpbWidth'(1) : spb_reg;
  assign start_cnt = (start_reg == '0) ? StartWidth'(1) : start_reg;

  // new divisor: rebuild tick_count mod spb serially
  always_comb begin
    mod_req.start    = spb_write;
    mod_req.dividend = tick_count;
    mod_req.divisor  = (cfg_data[SpbWidth-1:0] == '0) ? SpbWidth'(1)
                                                      : cfg_data[SpbWidth-1:0];
  end

  ouart_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // ------------------------------------------------------------ handshakes
  assign s_tready = !mod_rsp.busy && !skid_valid && !spb_write;
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  // ------------------------------------------------------------- tick path
  // rem tracks tick_count mod spb; wrap of the 8-bit counter restarts it.
  assign tc_inc   = tick_count + 1'b1;
  assign rem_inc  = {1'b0, rem} + 1'b1;
  assign rem_tick = (tc_inc == '0 || rem_inc == {1'b0, spb}) ? '0
                                                              : rem_inc[SpbWidth-1:0];
  assign tc_wait  = s_tdata[0] ? '0 : tc_inc;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    rem_next        = rem;
    shift_byte_next = shift_byte;
    held_byte_next  = held_byte;
    new_flag_next   = new_flag;
    if (s_tuser == OpRead) begin
      new_flag_next = 1'b0;
    end else begin
      tick_count_next = tc_inc;
      rem_next        = rem_tick;
      case (phase)
        PH_DATA: begin
          if (rem_tick == '0) begin
            shift_byte_next = {s_tdata[0], shift_byte[DataBits-1:1]};
            if (tc_inc == {spb, 3'b000}) begin
              held_byte_next  = {s_tdata[0], shift_byte[DataBits-1:1]};
              new_flag_next   = 1'b1;
              phase_next      = PH_STOP;
              tick_count_next = '0;
              rem_next        = '0;
            end
          end
        end
        PH_STOP: begin
          if (tc_inc == CountWidth'(spb)) begin
            phase_next = PH_WAIT;
          end
        end
        default: begin
          // waiting for start; also covers the unused phase code
          tick_count_next = tc_wait;
          if (s_tdata[0]) begin
            rem_next = '0;
          end
          if (tc_wait == CountWidth'(start_cnt)) begin
            phase_next      = PH_DATA;
            tick_count_next = '0;
            rem_next        = '0;
            shift_byte_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      tick_count <= '0;
      rem        <= '0;
      shift_byte <= '0;
      held_byte  <= '0;
      new_flag   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      rem        <= rem_next;
      shift_byte <= shift_byte_next;
      held_byte  <= held_byte_next;
      new_flag   <= new_flag_next;
    end else if (mod_rsp.done) begin
      rem <= mod_rsp.rem;
    end
  end

  always_comb begin
    result.received_byte  = held_byte_next;
    result.byte_available = new_flag_next;
    result.receiving      = (phase_next == PH_DATA) || (phase_next == PH_STOP);
  end

  // ------------------------------------------------- output reg + skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b000000, out_data};

endmodule

/* rtl/ouart_mod_unit.sv */
// Bit-serial remainder unit: count modulo divisor, one dividend bit per cycle.
`timescale 1ns / 1ps
module ouart_mod_unit
  import ouart_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                  busy;
  logic [StepWidth-1:0]  step;
  logic [CountWidth-1:0] bits;
  logic [SpbWidth-1:0]   divisor;
  logic [SpbWidth-1:0]   acc;
  logic [SpbWidth:0]     acc_shift;
  logic [SpbWidth-1:0]   acc_next;

  always_comb begin
    acc_shift = {acc, bits[CountWidth-1]};
    if (acc_shift >= {1'b0, divisor}) begin
      acc_next = SpbWidth'(acc_shift - {1'b0, divisor});
    end else begin
      acc_next = acc_shift[SpbWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == StepWidth'(CountWidth - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc     <= '0;
      bits    <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      acc  <= acc_next;
      bits <= {bits[CountWidth-2:0], 1'b0};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = busy && (step == StepWidth'(CountWidth - 1)) && !req.start;
  assign rsp.rem  = acc_next;

endmodule
